### hdl/ilst_pkg.sv
// ----------------------------------------------------------------------------
// ilst_pkg
// shared constants, codes and types of the indexed list store
// ----------------------------------------------------------------------------
package ilst_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = $clog2(DEPTH + 1);
  // compare width, wide enough for both a position field and a length
  localparam int unsigned CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ     = 3'd0,
    MODE_INS_HEAD = 3'd1,
    MODE_APPEND   = 3'd2,
    MODE_INS_AT   = 3'd3,
    MODE_DELETE   = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } cell_op_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e           op;
    logic [CMP_W-1:0]   pos;
    logic [DATA_W-1:0]  data;
    logic [CMP_W-1:0]   rd_pos;
  } cell_ctl_t;

endpackage

### hdl/ilst_in_if.sv
// ----------------------------------------------------------------------------
// ilst_in_if
// request channel: one operation per beat
// ----------------------------------------------------------------------------
interface ilst_in_if;
  import ilst_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [POS_W-1:0]    position;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output mode, output position, output data_in,
                  input ready);
  modport sink   (input valid, input mode, input position, input data_in,
                  output ready);
endinterface

### hdl/ilst_out_if.sv
// ----------------------------------------------------------------------------
// ilst_out_if
// result channel: one result per beat
// ----------------------------------------------------------------------------
interface ilst_out_if;
  import ilst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic                     found;
  logic [STAT_W-1:0]        status;
  logic [POS_W-1:0]         list_length;

  modport source (output valid, output read_value, output found, output status,
                  output list_length, input ready);
  modport sink   (input valid, input read_value, input found, input status,
                  input list_length, output ready);
endinterface

### hdl/indexed_list_store_top.sv
// ----------------------------------------------------------------------------
// indexed_list_store_top
// bounded ordered list of signed 32-bit values with insert/delete by position
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH slot cells kept in list order. Insert at the
// head, append, insert before a position and delete at a position all take
// effect in the cells as the beat is accepted: every cell compares its own
// index with the target and takes its own value, the new data or a neighbor's
// value. With the result channel ready these operations sustain one beat per
// cycle. For a read the addressed cell drops its value into a read chain that
// moves one cell per clock toward the last cell, and the next request beat is
// taken once the value has left the chain. A read past the end answers at once
// with -1. Every request beat gives exactly one result beat; a finished result
// waits in an output register, and after reset the list is empty.
// ----------------------------------------------------------------------------
module indexed_list_store_top
  import ilst_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  ilst_in_if.sink       in_if,
  ilst_out_if.source    out_if
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   length_q, length_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CMP_W-1:0]   rd_pos_q, rd_pos_d;

  // output register
  logic               ovalid_q, ovalid_d;
  logic [DATA_W-1:0]  oval_q, oval_d;
  logic               ofound_q, ofound_d;
  logic [STAT_W-1:0]  ostat_q, ostat_d;
  logic [POS_W-1:0]   olen_q, olen_d;

  logic               accept;
  logic               full;
  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   len_x;
  logic [CMP_W-1:0]   len_new_x;
  cell_ctl_t          ctl;

  logic [DATA_W-1:0]  entry_w [DEPTH];
  logic [DATA_W-1:0]  rd_w    [DEPTH];

  // take a beat only when idle and the result slot is free or draining
  assign in_if.ready = (state_q == S_IDLE) && (!ovalid_q || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;

  assign full  = (length_q >= LEN_W'(DEPTH));
  assign pos_x = CMP_W'(in_if.position);
  assign len_x = CMP_W'(length_q);

  always_comb begin
    state_d   = state_q;
    length_d  = length_q;
    cnt_d     = cnt_q;
    rd_pos_d  = rd_pos_q;
    ctl.op    = OP_HOLD;
    ctl.pos   = pos_x;
    ctl.data  = in_if.data_in;
    ctl.rd_pos = rd_pos_q;

    ovalid_d  = ovalid_q && !out_if.ready;
    oval_d    = oval_q;
    ofound_d  = ofound_q;
    ostat_d   = ostat_q;
    olen_d    = olen_q;

    len_new_x = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          oval_d   = '0;
          ofound_d = 1'b0;
          ostat_d  = ST_DONE;
          ovalid_d = 1'b1;
          unique case (in_if.mode)
            MODE_READ: begin
              if (pos_x < len_x) begin
                // hit: walk the read chain, result comes later
                ovalid_d = 1'b0;
                rd_pos_d = pos_x;
                cnt_d    = '0;
                state_d  = S_READ;
              end else begin
                oval_d  = '1;
                ostat_d = ST_RANGE;
              end
            end
            MODE_INS_HEAD: begin
              if (full) begin
                ostat_d = ST_FULL;
              end else begin
                ctl.op   = OP_INS;
                ctl.pos  = '0;
                length_d = length_q + 1'b1;
              end
            end
            MODE_APPEND: begin
              if (full) begin
                ostat_d = ST_FULL;
              end else begin
                ctl.op   = OP_INS;
                ctl.pos  = len_x;
                length_d = length_q + 1'b1;
              end
            end
            MODE_INS_AT: begin
              if (pos_x > len_x) begin
                ostat_d = ST_RANGE;
              end else if (full) begin
                ostat_d = ST_FULL;
              end else begin
                ctl.op   = OP_INS;
                length_d = length_q + 1'b1;
              end
            end
            MODE_DELETE: begin
              if (pos_x < len_x) begin
                ctl.op   = OP_DEL;
                length_d = length_q - 1'b1;
              end else begin
                ostat_d = ST_RANGE;
              end
            end
            default: begin
              ostat_d = ST_RANGE;
            end
          endcase
          len_new_x = CMP_W'(length_d);
          olen_d    = len_new_x[POS_W-1:0];
        end
      end
      S_READ: begin
        // once the counter ends, the last cell of the chain holds the value
        if (cnt_q == CNT_W'(DEPTH)) begin
          ovalid_d = 1'b1;
          oval_d   = rd_w[DEPTH-1];
          ofound_d = 1'b1;
          ostat_d  = ST_DONE;
          len_new_x = len_x;
          olen_d   = len_new_x[POS_W-1:0];
          state_d  = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // row of slot cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w, rd_in_w;
    if (i == 0) begin : g_first
      assign left_w  = '0;
      assign rd_in_w = '0;
    end else begin : g_mid
      assign left_w  = entry_w[i-1];
      assign rd_in_w = rd_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = entry_w[i];
    end else begin : g_inner
      assign right_w = entry_w[i+1];
    end

    ilst_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (CMP_W'(i)),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .rd_i    (rd_in_w),
      .entry_o (entry_w[i]),
      .rd_o    (rd_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      length_q <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      length_q <= length_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    rd_pos_q <= rd_pos_d;
    oval_q   <= oval_d;
    ofound_q <= ofound_d;
    ostat_q  <= ostat_d;
    olen_q   <= olen_d;
  end

  assign out_if.valid       = ovalid_q;
  assign out_if.read_value  = oval_q;
  assign out_if.found       = ofound_q;
  assign out_if.status      = ostat_q;
  assign out_if.list_length = olen_q;

endmodule

### hdl/ilst_cell.sv
// ----------------------------------------------------------------------------
// ilst_cell
// one list slot: shifts with its neighbors and forwards the read chain
// ----------------------------------------------------------------------------
module ilst_cell
  import ilst_pkg::*;
(
  input  logic              clk_i,
  input  logic [CMP_W-1:0]  idx_i,
  input  cell_ctl_t         ctl_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  input  logic [DATA_W-1:0] rd_i,
  output logic [DATA_W-1:0] entry_o,
  output logic [DATA_W-1:0] rd_o
);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic [DATA_W-1:0] rd_q, rd_d;

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      OP_INS: begin
        if (idx_i > ctl_i.pos) begin
          entry_d = left_i;
        end else if (idx_i == ctl_i.pos) begin
          entry_d = ctl_i.data;
        end
      end
      OP_DEL: begin
        if (idx_i >= ctl_i.pos) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
    // selected slot drops its value into the chain, others pass it along
    rd_d = (idx_i == ctl_i.rd_pos) ? entry_q : rd_i;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    rd_q    <= rd_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = rd_q;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the indexed list store: a directed opening, then
// about nine hundred random list operations that grow, shrink and refill the
// store, each result compared field by field against an in-bench list model
// ----------------------------------------------------------------------------
module testbench;
  import ilst_pkg::*;

  // modes 5..7 have no meaning and must be ignored with a range status
  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_MID   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

  localparam logic signed [DATA_W-1:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] WORD_NONE = -32'sd1;
  localparam logic [POS_W-1:0]         POS_TOP   = '1;

  // the two full-store bursts add roughly another hundred and thirty ops
  localparam int unsigned RANDOM_OPS  = 800;
  // no idling while the count of sent ops lies between these two bounds
  localparam int unsigned CALM_LO     = 300;
  localparam int unsigned CALM_HI     = 420;
  // the result side holds off once, long enough to back up the request side
  localparam int unsigned HOLD_AT     = 600;
  localparam int unsigned HOLD_CYCLES = 400;
  // worst case is a read on every op plus gaps and the hold
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_in;
    bit                       drain_first;  // wait for every result before this beat
  } list_op_t;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         list_length;
  } list_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ilst_in_if  req_ch ();
  ilst_out_if rsp_ch ();

  indexed_list_store_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_ch),
    .out_if (rsp_ch)
  );

  // 4 ns period
  always #2 clk_i = ~clk_i;

  // ops waiting to be driven, and results owed by the dut in order
  list_op_t     op_queue[$];
  list_result_t owed_results[$];

  // list contents as the dut should hold them, head first
  logic signed [DATA_W-1:0] shadow_list[$];

  // the sent and checked counters move with nonblocking updates only, so every
  // reader sees the value from before the current edge
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors  = 0;
  int unsigned cycles    = 0;

  // coverage tallies for the summary
  int unsigned n_read_hit  = 0;
  int unsigned n_read_miss = 0;
  int unsigned n_range     = 0;
  int unsigned n_full      = 0;
  int unsigned n_inserts   = 0;
  int unsigned n_deletes   = 0;
  int unsigned peak_len    = 0;

  // list length as seen while planning the stimulus
  int unsigned plan_len = 0;

  // -- list model ------------------------------------------------------------

  // applies one op to the shadow list and returns the result the dut owes
  function automatic list_result_t apply_list_op(list_op_t op);
    list_result_t r;
    int unsigned  len;
    len          = shadow_list.size();
    r.read_value = '0;
    r.found      = 1'b0;
    r.status     = ST_DONE;
    case (op.mode)
      MODE_READ: begin
        if (op.position < len) begin
          r.read_value = shadow_list[op.position];
          r.found      = 1'b1;
          n_read_hit++;
        end else begin
          // read past the end answers -1 with no hit
          r.read_value = WORD_NONE;
          r.status     = ST_RANGE;
          n_read_miss++;
        end
      end
      MODE_INS_HEAD, MODE_APPEND: begin
        if (len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_list.insert((op.mode == MODE_INS_HEAD) ? 0 : int'(len), op.data_in);
          n_inserts++;
        end
      end
      MODE_INS_AT: begin
        // range is checked before fullness
        if (op.position > len) begin
          r.status = ST_RANGE;
        end else if (len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_list.insert(int'(op.position), op.data_in);
          n_inserts++;
        end
      end
      MODE_DELETE: begin
        if (op.position < len) begin
          shadow_list.delete(int'(op.position));
          n_deletes++;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    if (r.status == ST_RANGE) n_range++;
    if (r.status == ST_FULL) n_full++;
    r.list_length = POS_W'(shadow_list.size());
    if (shadow_list.size() > peak_len) peak_len = shadow_list.size();
    return r;
  endfunction

  // -- stimulus planning -----------------------------------------------------

  // queues one op and tracks the length it leaves behind
  task automatic plan_op(logic [MODE_W-1:0] mode, logic [POS_W-1:0] position,
                         logic signed [DATA_W-1:0] data_in, bit drain_first = 1'b0);
    list_op_t op;
    op.mode        = mode;
    op.position    = position;
    op.data_in     = data_in;
    op.drain_first = drain_first;
    op_queue.push_back(op);
    case (mode)
      MODE_INS_HEAD, MODE_APPEND: if (plan_len < DEPTH) plan_len++;
      MODE_INS_AT: if (position <= plan_len && plan_len < DEPTH) plan_len++;
      MODE_DELETE: if (position < plan_len) plan_len--;
      default: ;
    endcase
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 39))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return WORD_NONE;
      default: return $urandom;
    endcase
  endfunction

  // mostly positions near the live list, sometimes anywhere in the field
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, plan_len));
    return POS_W'($urandom_range(0, int'(POS_TOP)));
  endfunction

  // bias: 0 grow, 1 shrink, 2 balanced
  task automatic plan_random_op(int unsigned bias, bit drain_first = 1'b0);
    int unsigned weight[6];
    int unsigned r;
    int unsigned acc;
    int unsigned k;
    case (bias)
      0:       weight = '{15, 20, 20, 35, 8, 2};
      1:       weight = '{15, 8, 8, 14, 53, 2};
      default: weight = '{25, 12, 12, 23, 25, 3};
    endcase
    r   = $urandom_range(0, 99);
    acc = 0;
    k   = 0;
    while (k < 5 && r >= acc + weight[k]) begin
      acc += weight[k];
      k++;
    end
    case (k)
      0: plan_op(MODE_READ, pick_position(), pick_word(), drain_first);
      1: plan_op(MODE_INS_HEAD, pick_position(), pick_word(), drain_first);
      2: plan_op(MODE_APPEND, pick_position(), pick_word(), drain_first);
      3: plan_op(MODE_INS_AT, pick_position(), pick_word(), drain_first);
      4: plan_op(MODE_DELETE, pick_position(), pick_word(), drain_first);
      default: plan_op(MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                       pick_position(), pick_word(), drain_first);
    endcase
  endtask

  // inserts until the store is full, then keeps pushing into it
  task automatic plan_fill_burst();
    int unsigned extra;
    while (plan_len < DEPTH) begin
      case ($urandom_range(0, 3))
        0:       plan_op(MODE_INS_HEAD, pick_position(), pick_word());
        1:       plan_op(MODE_APPEND, pick_position(), pick_word());
        2:       plan_op(MODE_INS_AT, POS_W'($urandom_range(0, plan_len)), pick_word());
        default: plan_op(MODE_READ, pick_position(), pick_word());
      endcase
    end
    // drops on a full store, plus an out-of-range insert and reads at the edge
    plan_op(MODE_APPEND, '0, pick_word());
    plan_op(MODE_INS_HEAD, '0, pick_word());
    plan_op(MODE_INS_AT, POS_W'(DEPTH), pick_word());
    plan_op(MODE_INS_AT, POS_W'(DEPTH + 1), pick_word());
    plan_op(MODE_READ, POS_W'(DEPTH - 1), pick_word());
    plan_op(MODE_READ, POS_W'(DEPTH), pick_word());
    for (extra = 0; extra < 6; extra++) plan_random_op(2);
  endtask

  // -- idling ----------------------------------------------------------------

  function automatic bit take_break();
    if (n_sent >= CALM_LO && n_sent < CALM_HI) return 1'b0;
    return $urandom_range(0, 99) < 6;
  endfunction

  // -- request driver --------------------------------------------------------

  list_op_t cur_op;

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    bit           taken;
    list_result_t owed;
    if (!rst_ni) begin
      req_ch.valid    <= 1'b0;
      req_ch.mode     <= MODE_READ;
      req_ch.position <= '0;
      req_ch.data_in  <= '0;
    end else begin
      taken = req_ch.valid && req_ch.ready;
      if (taken) begin
        // the op takes effect on the list at the beat that accepts it
        owed = apply_list_op(cur_op);
        owed_results.push_back(owed);
        n_sent <= n_sent + 1;
      end
      if (!req_ch.valid || taken) begin
        // a drain marker holds the op back until every result is in
        if (op_queue.size() > 0 && !take_break() &&
            (!op_queue[0].drain_first || (!taken && n_checked == n_sent))) begin
          cur_op           = op_queue.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.mode     <= cur_op.mode;
          req_ch.position <= cur_op.position;
          req_ch.data_in  <= cur_op.data_in;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // -- result monitor --------------------------------------------------------

  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    list_result_t want;
    int unsigned  left;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_results.size() == 0) begin
          $error("result beat with no op outstanding");
          n_errors++;
        end else begin
          want = owed_results.pop_front();
          if (rsp_ch.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, rsp_ch.read_value);
            n_errors++;
          end
          if (rsp_ch.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
            n_errors++;
          end
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            n_errors++;
          end
          if (rsp_ch.list_length !== want.list_length) begin
            $error("list_length: expected %0d, got %0d", want.list_length,
                   rsp_ch.list_length);
            n_errors++;
          end
          n_checked <= n_checked + 1;
        end
      end
      // one long hold-off, counted here, while the driver keeps offering
      left = hold_left;
      if (left > 0) begin
        left--;
      end else if (!hold_done && n_sent >= HOLD_AT) begin
        left = HOLD_CYCLES;
        hold_done <= 1'b1;
      end
      hold_left    <= left;
      rsp_ch.ready <= (left == 0) && !take_break();
    end
  end

  // -- watchdog --------------------------------------------------------------

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $error("no progress after %0d cycles, %0d of %0d results checked",
             cycles, n_checked, n_sent);
      $display("indexed_list_store_top test failed");
      $finish;
    end
  end

  // -- sequence --------------------------------------------------------------

  initial begin : run
    int unsigned i;
    int unsigned bias;
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_READ;
    req_ch.position = '0;
    req_ch.data_in  = '0;
    rsp_ch.ready    = 1'b0;

    // directed: empty-store corners, extremes of data and position, odd modes
    plan_op(MODE_READ, '0, pick_word());          // read on empty misses
    plan_op(MODE_DELETE, '0, pick_word());        // delete on empty ignored
    plan_op(MODE_INS_AT, 7'd1, pick_word());      // insert beyond length ignored
    plan_op(MODE_INS_AT, '0, WORD_MAX);           // position 0 acts as head insert
    plan_op(MODE_INS_HEAD, POS_TOP, WORD_MIN);
    plan_op(MODE_APPEND, POS_TOP, '0);
    plan_op(MODE_APPEND, '0, WORD_NONE);
    plan_op(MODE_INS_AT, 7'd4, 32'sh5555_5555);   // position equal to length appends
    plan_op(MODE_INS_AT, 7'd2, 32'shAAAA_AAAA);
    plan_op(MODE_READ, '0, WORD_NONE);
    plan_op(MODE_READ, 7'd5, '0);
    plan_op(MODE_READ, 7'd6, WORD_MAX);           // first position past the end
    plan_op(MODE_READ, POS_TOP, WORD_MIN);
    plan_op(MODE_INS_AT, POS_TOP, WORD_MAX);
    plan_op(MODE_DELETE, 7'd5, '0);               // delete the tail
    plan_op(MODE_DELETE, '0, '0);                 // delete the head
    plan_op(MODE_DELETE, POS_TOP, WORD_NONE);
    plan_op(MODE_DELETE, 7'd4, '0);               // delete at length ignored
    plan_op(MODE_UNUSED_FIRST, '0, WORD_MAX);
    plan_op(MODE_UNUSED_MID, POS_TOP, WORD_MIN);
    plan_op(MODE_UNUSED_LAST, 7'd1, $urandom);
    plan_op(MODE_READ, 7'd1, '0);
    plan_op(MODE_READ, 7'd3, '0);

    // random: segments that grow, shrink or churn, with full-store bursts
    for (i = 0; i < RANDOM_OPS; i++) begin
      if (i % 40 == 0) bias = $urandom_range(0, 2);
      if (i == 80 || i == 520) begin
        plan_fill_burst();
      end else begin
        // the sender stalls for a full drain at the start and once mid-run
        plan_random_op(bias, i == 0 || i == 700);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_queue.size() != 0 || req_ch.valid || n_checked != n_sent)
      @(posedge clk_i);
    // let any stray beat show up before the verdict
    repeat (2 * DEPTH + 8) @(posedge clk_i);

    $display("ran %0d ops: %0d inserts, %0d deletes, %0d read hits, %0d read misses",
             n_sent, n_inserts, n_deletes, n_read_hit, n_read_miss);
    $display("ignored: %0d out of range, %0d on full store; longest list %0d of %0d",
             n_range, n_full, peak_len, DEPTH);
    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("indexed_list_store_top test passed");
    end else begin
      $display("indexed_list_store_top test failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ilst_pkg.sv
hdl/ilst_in_if.sv
hdl/ilst_out_if.sv
hdl/ilst_cell.sv
hdl/indexed_list_store_top.sv
dv/testbench.sv
